// File: hdl/kqrs_pkg.sv
// ----------------------------------------------------------------------------
// kqrs_pkg: shared types and constants for the 2-D quadrature row summer
// Sequencer states, multiplier request/response records, node tables and
// the reciprocals used for the constant divisions.
// ----------------------------------------------------------------------------
`default_nettype none

package kqrs_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_G,
    ST_SQ,
    ST_T,
    ST_DIV,
    ST_H,
    ST_W,
    ST_I1,
    ST_I2,
    ST_OUT
  } kqrs_state_t;

  typedef enum logic [2:0] {
    SH_NONE,
    SH_FRAC,
    SH_WORD,
    SH_DIV6,
    SH_DIV324
  } kqrs_shift_t;

  typedef struct packed {
    logic        start;
    kqrs_shift_t sh;
  } kqrs_mul_req_t;

  typedef struct packed {
    logic done;
    logic clip;
  } kqrs_mul_rsp_t;

  localparam logic [31:0] NODE_LOW  = 32'd484050116;
  localparam logic [31:0] NODE_MID  = 32'd2147483648;
  localparam logic [31:0] NODE_HIGH = 32'd3810917180;

  // Rounded-up reciprocals that give exact truncating quotients for magnitudes
  // up to 2^63: the product is taken down by 66 bits for six and 72 for 324.
  localparam logic [63:0] RECIP_6   = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [63:0] RECIP_324 = 64'd14575205194042114858;

  function automatic logic [31:0] node_pos(input logic [1:0] idx);
    logic [31:0] c;
    case (idx)
      2'd0:    c = NODE_LOW;
      2'd1:    c = NODE_MID;
      2'd2:    c = NODE_HIGH;
      default: c = NODE_MID;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] node_wt(input logic [1:0] idx);
    logic [3:0] w;
    case (idx)
      2'd1:    w = 4'd8;
      default: w = 4'd5;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: hdl/kernel_quadrature_2d_row_sum.sv
// ----------------------------------------------------------------------------
// kernel_quadrature_2d_row_sum: row-wise 2-D Gauss-Legendre quadrature
// Each item takes 36 multiplies (min kernel) or 63 (cubic) on the one shared unit;
// in_stall holds off the next item until this one's result is registered.
// A stalled result delays the next.
// Reset clears the running sum and clip flag and selects the cubic kernel.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_quadrature_2d_row_sum #(
  parameter int FRAC_BITS = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      cfg_kernel_cubic,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire                      in_row_start,
  input  wire logic signed [31:0]  in_x_low,
  input  wire logic signed [31:0]  in_x_high,
  input  wire logic signed [31:0]  in_x_val_first,
  input  wire logic signed [31:0]  in_x_val_mid,
  input  wire logic signed [31:0]  in_x_val_last,
  input  wire logic signed [31:0]  in_y_low,
  input  wire logic signed [31:0]  in_y_high,
  input  wire logic signed [31:0]  in_y_val_first,
  input  wire logic signed [31:0]  in_y_val_mid,
  input  wire logic signed [31:0]  in_y_val_last,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [63:0]       out_row_total,
  output logic                     out_saturated
);
  import kqrs_pkg::*;

  kqrs_state_t state_r, state_nxt;
  logic        cubic_r;
  logic        issued_r, issued_nxt;
  logic [1:0]  a_r, a_nxt, b_r, b_nxt;
  logic        side_r, side_nxt;
  logic signed [31:0] xl_r, yl_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [31:0] xv_r [3];
  logic signed [31:0] yv_r [3];
  logic signed [34:0] px_r [3];
  logic signed [34:0] py_r [3];
  logic signed [34:0] px_nxt, py_nxt;
  logic signed [63:0] g_r, g_nxt, k_r, k_nxt, sq_r, sq_nxt, h_r, h_nxt;
  logic signed [63:0] acc_r, acc_nxt, run_r, run_nxt, i1_r, i1_nxt;
  logic        clip_now_r, clip_now_nxt, clip_seen_r, clip_seen_nxt;
  logic        d324_r, d324_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [63:0] out_total_r, out_total_nxt;
  logic        out_sat_r, out_sat_nxt;

  kqrs_mul_req_t      mreq;
  kqrs_mul_rsp_t      mrsp;
  logic signed [63:0] mul_a, mul_b, mres;

  logic signed [34:0] m, big;
  logic signed [36:0] tri_m;
  logic signed [63:0] kmin;
  logic signed [64:0] sum_acc, sum_run;
  logic signed [63:0] acc_sat, run_sat;
  logic        acc_ovf, run_ovf;
  logic        accept;

  kqrs_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mrsp),
    .res   (mres)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    m      = (px_r[a_r] < py_r[b_r]) ? px_r[a_r] : py_r[b_r];
    big    = (px_r[a_r] < py_r[b_r]) ? py_r[b_r] : px_r[a_r];
    tri_m  = 37'(big) + (37'(big) <<< 1) - 37'(m);
    kmin   = 64'(m) <<< FRAC_BITS;
    sum_acc = 65'(acc_r) + 65'(mres);
    acc_ovf = (sum_acc[64] != sum_acc[63]);
    acc_sat = acc_ovf ? (sum_acc[64] ? 64'sh8000_0000_0000_0000
                                     : 64'sh7FFF_FFFF_FFFF_FFFF) : sum_acc[63:0];
    sum_run = 65'(run_r) + 65'(mres);
    run_ovf = (sum_run[64] != sum_run[63]);
    run_sat = run_ovf ? (sum_run[64] ? 64'sh8000_0000_0000_0000
                                     : 64'sh7FFF_FFFF_FFFF_FFFF) : sum_run[63:0];
    px_nxt  = 35'(xl_r) + mres[34:0];
    py_nxt  = 35'(yl_r) + mres[34:0];
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    side_nxt      = side_r;
    g_nxt         = g_r;
    k_nxt         = k_r;
    sq_nxt        = sq_r;
    h_nxt         = h_r;
    acc_nxt       = acc_r;
    run_nxt       = run_r;
    i1_nxt        = i1_r;
    clip_now_nxt  = clip_now_r;
    clip_seen_nxt = clip_seen_r;
    d324_nxt      = d324_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    out_sat_nxt   = out_sat_r;
    mreq.start    = 1'b0;
    mreq.sh       = SH_NONE;
    mul_a         = '0;
    mul_b         = '0;

    if (state_r != ST_IDLE && state_r != ST_OUT) begin
      mreq.start = !issued_r;
      issued_nxt = 1'b1;
      if (mrsp.done) begin
        issued_nxt   = 1'b0;
        clip_now_nxt = clip_now_r | mrsp.clip;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          a_nxt        = '0;
          b_nxt        = '0;
          side_nxt     = 1'b0;
          acc_nxt      = '0;
          clip_now_nxt = 1'b0;
          issued_nxt   = 1'b0;
          if (in_row_start) begin
            run_nxt       = '0;
            clip_seen_nxt = 1'b0;
          end
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        mreq.sh = SH_WORD;
        mul_a   = side_r ? 64'(dy_r) : 64'(dx_r);
        mul_b   = $signed({32'd0, node_pos(a_r)});
        if (mrsp.done) begin
          if (a_r == 2'd2) begin
            a_nxt    = '0;
            side_nxt = 1'b1;
            if (side_r) begin
              state_nxt = ST_G;
            end
          end else begin
            a_nxt = a_r + 2'd1;
          end
        end
      end
      ST_G: begin
        mreq.sh = SH_FRAC;
        mul_a   = 64'(xv_r[a_r]);
        mul_b   = 64'(yv_r[b_r]);
        if (mrsp.done) begin
          g_nxt = mres;
          if (cubic_r) begin
            state_nxt = ST_SQ;
          end else begin
            k_nxt     = kmin;
            state_nxt = ST_H;
          end
        end
      end
      ST_SQ: begin
        mreq.sh = SH_FRAC;
        mul_a   = 64'(m);
        mul_b   = 64'(m);
        if (mrsp.done) begin
          sq_nxt    = mres;
          state_nxt = ST_T;
        end
      end
      ST_T: begin
        mreq.sh = SH_NONE;
        mul_a   = sq_r;
        mul_b   = 64'(tri_m);
        if (mrsp.done) begin
          k_nxt     = mres;
          d324_nxt  = 1'b0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        mreq.sh = d324_r ? SH_DIV324 : SH_DIV6;
        mul_a   = k_r;
        mul_b   = d324_r ? $signed(RECIP_324) : $signed(RECIP_6);
        if (mrsp.done) begin
          k_nxt     = mres;
          state_nxt = d324_r ? ST_I1 : ST_H;
        end
      end
      ST_H: begin
        mreq.sh = SH_FRAC;
        mul_a   = g_r;
        mul_b   = k_r;
        if (mrsp.done) begin
          h_nxt     = mres;
          state_nxt = ST_W;
        end
      end
      ST_W: begin
        mreq.sh = SH_NONE;
        mul_a   = h_r;
        mul_b   = 64'(node_wt(a_r) * node_wt(b_r));
        if (mrsp.done) begin
          acc_nxt      = acc_sat;
          clip_now_nxt = clip_now_r | mrsp.clip | acc_ovf;
          if (b_r == 2'd2) begin
            b_nxt = '0;
            if (a_r == 2'd2) begin
              k_nxt     = acc_sat;
              d324_nxt  = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              a_nxt     = a_r + 2'd1;
              state_nxt = ST_G;
            end
          end else begin
            b_nxt     = b_r + 2'd1;
            state_nxt = ST_G;
          end
        end
      end
      ST_I1: begin
        mreq.sh = SH_FRAC;
        mul_a   = k_r;
        mul_b   = 64'(dx_r);
        if (mrsp.done) begin
          i1_nxt    = mres;
          state_nxt = ST_I2;
        end
      end
      ST_I2: begin
        mreq.sh = SH_FRAC;
        mul_a   = i1_r;
        mul_b   = 64'(dy_r);
        if (mrsp.done) begin
          run_nxt      = run_sat;
          clip_now_nxt = clip_now_r | mrsp.clip | run_ovf;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          clip_seen_nxt = clip_seen_r | clip_now_r;
          out_valid_nxt = 1'b1;
          out_total_nxt = run_r;
          out_sat_nxt   = clip_seen_r | clip_now_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      cubic_r     <= 1'b1;
      run_r       <= '0;
      clip_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      run_r       <= run_nxt;
      clip_seen_r <= clip_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cubic_r <= cfg_kernel_cubic;
      end
    end
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    side_r      <= side_nxt;
    g_r         <= g_nxt;
    k_r         <= k_nxt;
    sq_r        <= sq_nxt;
    h_r         <= h_nxt;
    acc_r       <= acc_nxt;
    i1_r        <= i1_nxt;
    clip_now_r  <= clip_now_nxt;
    d324_r      <= d324_nxt;
    out_total_r <= out_total_nxt;
    out_sat_r   <= out_sat_nxt;
    if (state_r == ST_POS && mrsp.done) begin
      if (side_r) begin
        py_r[a_r] <= py_nxt;
      end else begin
        px_r[a_r] <= px_nxt;
      end
    end
    if (accept) begin
      xl_r  <= in_x_low;
      yl_r  <= in_y_low;
      dx_r  <= 33'(in_x_high) - 33'(in_x_low);
      dy_r  <= 33'(in_y_high) - 33'(in_y_low);
      xv_r[0] <= in_x_val_first;
      xv_r[1] <= in_x_val_mid;
      xv_r[2] <= in_x_val_last;
      yv_r[0] <= in_y_val_first;
      yv_r[1] <= in_y_val_mid;
      yv_r[2] <= in_y_val_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_total = out_total_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// File: hdl/kqrs_mulq.sv
// ----------------------------------------------------------------------------
// kqrs_mulq: multi-cycle signed 64 x 64 multiply with round and saturate
// Four 32 x 32 partial products, a rounding step and a final shift, clip
// and sign step; the result stays in place until the next request. In the
// divide modes the second operand is an unsigned reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module kqrs_mulq #(
  parameter int FRAC_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  kqrs_pkg::kqrs_mul_req_t     req,
  input  wire logic signed [63:0]     op_a,
  input  wire logic signed [63:0]     op_b,
  output kqrs_pkg::kqrs_mul_rsp_t     rsp,
  output logic signed [63:0]          res
);
  import kqrs_pkg::*;

  logic [63:0]  ua_r, ub_r;
  logic         neg_r;
  kqrs_shift_t  sh_r;
  logic [127:0] prod_r, prod_nxt;
  logic [2:0]   step_r, step_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic         clip_r, clip_nxt;
  logic signed [63:0] res_r, res_nxt;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rnd, shifted;
  logic [63:0]  mag, limit, mag_s;
  logic         over;

  always_comb begin
    ah = step_r[0] ? ua_r[63:32] : ua_r[31:0];
    bh = step_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp = ah * bh;
    case ({1'b0, step_r[0]} + {1'b0, step_r[1]})
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    case (sh_r)
      SH_FRAC: begin
        rnd     = 128'd1 << (FRAC_BITS - 1);
        shifted = prod_r >> FRAC_BITS;
      end
      SH_WORD: begin
        rnd     = 128'd1 << 31;
        shifted = prod_r >> 32;
      end
      SH_DIV6: begin
        rnd     = '0;
        shifted = prod_r >> 66;
      end
      SH_DIV324: begin
        rnd     = '0;
        shifted = prod_r >> 72;
      end
      default: begin
        rnd     = '0;
        shifted = prod_r;
      end
    endcase
    mag   = shifted[63:0];
    limit = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    over  = (shifted[127:64] != '0) || (mag > limit);
    mag_s = over ? limit : mag;
  end

  always_comb begin
    prod_nxt = prod_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    clip_nxt = clip_r;
    res_nxt  = res_r;
    if (req.start) begin
      prod_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r < 3'd4) begin
        prod_nxt = prod_r + pp_sh;
      end else if (step_r == 3'd4) begin
        prod_nxt = prod_r + rnd;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        clip_nxt = over;
        res_nxt  = neg_r ? -$signed(mag_s) : $signed(mag_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    prod_r <= prod_nxt;
    clip_r <= clip_nxt;
    res_r  <= res_nxt;
    if (req.start) begin
      ua_r <= op_a[63] ? 64'(-op_a) : 64'(op_a);
      if (req.sh == SH_DIV6 || req.sh == SH_DIV324) begin
        ub_r  <= op_b;
        neg_r <= op_a[63];
      end else begin
        ub_r  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
        neg_r <= op_a[63] ^ op_b[63];
      end
      sh_r <= req.sh;
    end
  end

  assign rsp.done = done_r;
  assign rsp.clip = clip_r;
  assign res      = res_r;

endmodule

`default_nettype wire
